>>> design/fpa_pkg.sv
// Shared types and constants of the Q24.8 fixed-point ALU.
package fpa_pkg;

	localparam int unsigned WordBits = 32;
	localparam int unsigned FracBits = 8;
	localparam int unsigned NumW = WordBits + FracBits;
	localparam int unsigned DivSteps = NumW;
	localparam int unsigned ProdBits = 2 * WordBits;
	localparam int unsigned HalfBits = WordBits / 2;

	typedef logic [WordBits-1:0] word_t;
	typedef logic [NumW-1:0] num_t;
	typedef logic [ProdBits-1:0] prod_t;

	typedef enum logic [3:0] {
		ACT_ADD = 4'd0,
		ACT_SUB = 4'd1,
		ACT_MUL = 4'd2,
		ACT_DIV = 4'd3,
		ACT_MIN = 4'd4,
		ACT_MAX = 4'd5,
		ACT_INC = 4'd6,
		ACT_DEC = 4'd7,
		ACT_I2F = 4'd8,
		ACT_F2I = 4'd9,
		ACT_CMP = 4'd10
	} action_t;

	// Item travelling down the row of divider cells.
	typedef struct packed {
		logic   vld;
		logic   is_div;
		logic   neg;
		logic   dz;
		logic   lt;
		logic   eq;
		logic   gt;
		word_t  res;
		num_t   rem;
		num_t   quo;
		word_t  den;
	} cell_t;

endpackage

>>> design/fpa_cell.sv
// One restoring-division cell: produces one quotient bit per cycle step while en is high.
module fpa_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fpa_pkg::cell_t  din,
	output fpa_pkg::cell_t  dout
);

	logic [fpa_pkg::NumW:0] trial;
	fpa_pkg::num_t          shifted;
	fpa_pkg::cell_t         nxt;
	logic                   vld_q;
	fpa_pkg::cell_t         pay_q;

	always_comb begin
		shifted = {din.rem[fpa_pkg::NumW-2:0], din.quo[fpa_pkg::NumW-1]};
		trial = {1'b0, shifted} - {{(fpa_pkg::NumW - fpa_pkg::WordBits + 1){1'b0}}, din.den};
		nxt = din;
		if (!trial[fpa_pkg::NumW]) begin
			nxt.rem = trial[fpa_pkg::NumW-1:0];
			nxt.quo = {din.quo[fpa_pkg::NumW-2:0], 1'b1};
		end else begin
			nxt.rem = shifted;
			nxt.quo = {din.quo[fpa_pkg::NumW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		dout = pay_q;
		dout.vld = vld_q;
	end

endmodule

>>> design/fixed_point_alu_q24_8.sv
// Top level of the Q24.8 fixed-point ALU: front stages, divider cell row and output register.
// Path from input transfer to result valid: 2 front stages, 40 cells, output register.
// Throughput: one transfer per cycle; the whole pipeline advances when the output is free.
// The divider is a row of 40 restoring cells, one quotient bit each.
// The multiplier is split into four 16x16 partial products over two stages.
// Reset clears all valid flags; payload registers are not reset.
module fixed_point_alu_q24_8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata, // action[3:0], operand_a[35:4], operand_b[67:36], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata  // result[31:0], less, equal, greater, div_by_zero, zero fill
);

	localparam int unsigned W = fpa_pkg::WordBits;
	localparam int unsigned H = fpa_pkg::HalfBits;
	localparam int unsigned N = fpa_pkg::NumW;

	logic                  en;
	logic [3:0]            act;
	logic signed [W-1:0]   a;
	logic signed [W-1:0]   b;

	logic                  v_s1, v_s2;
	logic [3:0]            act_s1;
	logic [W-1:0]          a_s1, b_s1;
	logic                  lt_s1, eq_s1, gt_s1;
	logic [W-1:0]          res_s1;
	logic [W-1:0]          ll_s1, lh_s1, hl_s1, hh_s1;
	logic [W-1:0]          a_mag_s1, b_mag_s1;
	logic                  neg_s1;

	logic [3:0]            act_s2;
	logic                  lt_s2, eq_s2, gt_s2, neg_s2, dz_s2;
	logic [W-1:0]          res_s2, a_mag_s2, b_mag_s2;
	logic [fpa_pkg::ProdBits-1:0] prod_s2;
	logic [fpa_pkg::ProdBits-1:0] uprod;

	fpa_pkg::cell_t        row [0:N];
	logic [W-1:0]          q_out;
	logic [W-1:0]          q_fix;
	logic [W-1:0]          fin;
	logic                  ovalid_q;
	logic [W-1:0]          ores_q;
	logic [3:0]            oflag_q;

	assign act = s_tdata[3:0];
	assign a = s_tdata[35:4];
	assign b = s_tdata[67:36];
	assign en = !ovalid_q || m_tready;
	assign s_tready = en;

	// Stage 1: compare, simple actions, partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= act;
			a_s1 <= a;
			b_s1 <= b;
			lt_s1 <= a < b;
			eq_s1 <= a == b;
			gt_s1 <= a > b;
			ll_s1 <= W'(a[H-1:0]) * W'(b[H-1:0]);
			lh_s1 <= W'(a[H-1:0]) * W'(b[W-1:H]);
			hl_s1 <= W'(a[W-1:H]) * W'(b[H-1:0]);
			hh_s1 <= W'(a[W-1:H]) * W'(b[W-1:H]);
			a_mag_s1 <= a[W-1] ? (~a + 1'b1) : a;
			b_mag_s1 <= b[W-1] ? (~b + 1'b1) : b;
			neg_s1 <= a[W-1] ^ b[W-1];
			unique case (act)
				fpa_pkg::ACT_ADD: res_s1 <= a + b;
				fpa_pkg::ACT_SUB: res_s1 <= a - b;
				fpa_pkg::ACT_MIN: res_s1 <= (a < b) ? a : b;
				fpa_pkg::ACT_MAX: res_s1 <= (a > b) ? a : b;
				fpa_pkg::ACT_INC: res_s1 <= a + 1'b1;
				fpa_pkg::ACT_DEC: res_s1 <= a - 1'b1;
				fpa_pkg::ACT_I2F: res_s1 <= a << fpa_pkg::FracBits;
				fpa_pkg::ACT_F2I: res_s1 <= a >>> fpa_pkg::FracBits;
				default:          res_s1 <= '0;
			endcase
		end
	end

	// Stage 2: unsigned sum of partial products, signs fixed via correction terms.
	always_comb begin
		uprod = {hh_s1, ll_s1}
			+ {{H{1'b0}}, lh_s1, {H{1'b0}}}
			+ {{H{1'b0}}, hl_s1, {H{1'b0}}};
		if (a_s1[W-1]) uprod = uprod - {b_s1, {W{1'b0}}};
		if (b_s1[W-1]) uprod = uprod - {a_s1, {W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2 <= act_s1;
			lt_s2 <= lt_s1;
			eq_s2 <= eq_s1;
			gt_s2 <= gt_s1;
			neg_s2 <= neg_s1;
			dz_s2 <= (act_s1 == fpa_pkg::ACT_DIV) && (b_s1 == '0);
			a_mag_s2 <= a_mag_s1;
			b_mag_s2 <= b_mag_s1;
			prod_s2 <= uprod;
			res_s2 <= res_s1;
		end
	end

	always_comb begin
		row[0].vld = v_s2;
		row[0].is_div = (act_s2 == fpa_pkg::ACT_DIV) && !dz_s2;
		row[0].neg = neg_s2;
		row[0].dz = dz_s2;
		row[0].lt = lt_s2;
		row[0].eq = eq_s2;
		row[0].gt = gt_s2;
		row[0].res = (act_s2 == fpa_pkg::ACT_MUL)
			? prod_s2[fpa_pkg::FracBits +: W] : res_s2;
		row[0].rem = '0;
		row[0].quo = {a_mag_s2, {fpa_pkg::FracBits{1'b0}}};
		row[0].den = b_mag_s2;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		fpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (row[i]),
			.dout   (row[i+1])
		);
	end

	assign q_out = row[N].quo[W-1:0];
	assign q_fix = row[N].neg ? (~q_out + 1'b1) : q_out;
	assign fin = row[N].is_div ? q_fix : row[N].res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (en) begin
			ovalid_q <= row[N].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ores_q <= fin;
			oflag_q <= {row[N].dz, row[N].gt, row[N].eq, row[N].lt};
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = {4'b0, oflag_q, ores_q};

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");
	a_ready : assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output register");
	a_flags : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[34:32]) == 1)
		else $error("comparison flags not exclusive");
	a_dz : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35] |-> m_tdata[31:0] == '0)
		else $error("divide by zero with non-zero result");

endmodule
